/* src/gtc_pkg.sv */
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, constants and helpers for the graph triangle counter.
// ----------------------------------------------------------------------------
package gtc_pkg;

  localparam int ACTION_W    = 2;
  localparam int VERTEX_W    = 6;
  localparam int COUNT_W     = 16;
  localparam int VERTEX_SPAN = 64;
  localparam int CHUNK_W     = 8;
  localparam int PC_W        = 4;

  localparam logic [ACTION_W-1:0] ACT_ADD_EDGE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COUNT    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_WR_B,
    ST_CNT_RD_I,
    ST_CNT_LD_I,
    ST_CNT_SCAN,
    ST_CNT_LD_J,
    ST_CNT_DONE
  } gtc_state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

  typedef struct packed {
    logic clr;
    logic load;
  } pop_ctl_t;

  function automatic logic [PC_W-1:0] popcount8(input logic [CHUNK_W-1:0] x);
    logic [PC_W-1:0] n;
    n = '0;
    for (int k = 0; k < CHUNK_W; k++) begin
      n = n + PC_W'(x[k]);
    end
    return n;
  endfunction

endpackage

/* src/gtc_if.sv */
// ----------------------------------------------------------------------------
// gtc interfaces
// Valid/ready channels for request items and count results.
// ----------------------------------------------------------------------------
interface gtc_item_if import gtc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VERTEX_W-1:0] vertex_a;
  logic [VERTEX_W-1:0] vertex_b;

  modport source (output valid, output action, output vertex_a, output vertex_b,
                  input ready);
  modport sink   (input valid, input action, input vertex_a, input vertex_b,
                  output ready);
endinterface

interface gtc_result_if import gtc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] triangle_count;

  modport source (output valid, output triangle_count, input ready);
  modport sink   (input valid, input triangle_count, output ready);
endinterface

/* src/gtc_adj_mem.sv */
// ----------------------------------------------------------------------------
// gtc_adj_mem
// Adjacency row memory, one write and one registered read port, with
// per-row valid flags so that reset and clear empty the matrix at once.
// ----------------------------------------------------------------------------
module gtc_adj_mem import gtc_pkg::*; #(
  parameter int ROWS   = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_ctl_t          ctl,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROWS-1:0]   wr_data,
  output logic [ROWS-1:0]   rd_data
);

  logic [ROWS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [ROWS-1:0] rd_q;
  logic            rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      row_valid <= '0;
    end else if (ctl.wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (ctl.rd_en) begin
      rd_valid <= row_valid[rd_addr];
    end
  end

  // a row never written since clear reads as empty
  assign rd_data = rd_q & {ROWS{rd_valid}};

endmodule

/* src/gtc_pop_acc.sv */
// ----------------------------------------------------------------------------
// gtc_pop_acc
// Shared popcount accumulator: shifts a loaded word out one byte per cycle
// and adds the set bits into a saturating tally.
// ----------------------------------------------------------------------------
module gtc_pop_acc import gtc_pkg::*; #(
  parameter int WORD_W = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  pop_ctl_t           ctl,
  input  logic [WORD_W-1:0]  load_word,
  output logic               busy,
  output logic [COUNT_W-1:0] tally
);

  logic [WORD_W-1:0] word;
  logic [COUNT_W:0]  sum;

  assign busy = (word != '0);
  assign sum  = {1'b0, tally} + (COUNT_W+1)'(popcount8(word[CHUNK_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctl.load) begin
      word <= load_word;
    end else if (busy) begin
      word <= word >> CHUNK_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      tally <= '0;
    end else if (busy) begin
      tally <= sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end
  end

endmodule

/* src/graph_triangle_counter_top.sv */
// ----------------------------------------------------------------------------
// graph_triangle_counter_top
// Triangle counter over an undirected graph kept as an adjacency bit matrix.
// ----------------------------------------------------------------------------
// add edge: ready again after ADD_RD_A, ADD_WR_A and ADD_WR_B; clear, unused action or dropped edge: next cycle
// count: reads each row i and scans j above i; each connected pair reads row j and loads
//   the common neighbours, stalling while the byte-wide popcount is busy
// one request in flight at a time; a result waits in the output register
// rst (synchronous) clears control state and row valid flags, no clearing pass
module graph_triangle_counter_top import gtc_pkg::*; #(
  parameter int NUM_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  gtc_item_if.sink    item,
  gtc_result_if.source result
);

  localparam int N      = (NUM_VERTICES < VERTEX_SPAN) ? NUM_VERTICES : VERTEX_SPAN;
  localparam int IW     = $clog2(N);
  localparam int WORD_W = ((N + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
  localparam logic [VERTEX_W:0] N_LIM   = (VERTEX_W+1)'(N);
  localparam logic [IW-1:0]     J_LAST  = IW'(N - 1);
  localparam logic [IW-1:0]     I_LAST  = IW'(N - 2);

  gtc_state_t state, state_next;
  logic [IW-1:0]      va, va_next, vb, vb_next;
  logic [IW-1:0]      i_idx, i_next, j_idx, j_next;
  logic [N-1:0]       row_i, row_i_next;
  logic               res_valid, res_valid_next;
  logic [COUNT_W-1:0] res_count, res_count_next;

  mem_ctl_t           mem_ctl;
  logic [IW-1:0]      rd_addr, wr_addr;
  logic [N-1:0]       wr_data, rd_data;
  pop_ctl_t           pop_ctl;
  logic [WORD_W-1:0]  load_word;
  logic               pop_busy;
  logic [COUNT_W-1:0] tally;

  logic               accept;
  logic               edge_ok;
  logic [N-1:0]       above;

  gtc_adj_mem #(.ROWS(N), .ADDR_W(IW)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  gtc_pop_acc #(.WORD_W(WORD_W)) u_pop (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pop_ctl),
    .load_word (load_word),
    .busy      (pop_busy),
    .tally     (tally)
  );

  assign item.ready            = (state == ST_IDLE);
  assign accept                = item.valid && item.ready;
  assign result.valid          = res_valid;
  assign result.triangle_count = res_count;

  // self-loops and endpoints beyond the vertex count are dropped
  assign edge_ok = (item.vertex_a != item.vertex_b) &&
                   ({1'b0, item.vertex_a} < N_LIM) &&
                   ({1'b0, item.vertex_b} < N_LIM);

  // third vertex must be above j so each triangle is seen once
  assign above     = ({N{1'b1}} << j_idx) << 1;
  assign load_word = WORD_W'(row_i & rd_data & above);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    va        <= va_next;
    vb        <= vb_next;
    i_idx     <= i_next;
    j_idx     <= j_next;
    row_i     <= row_i_next;
    res_count <= res_count_next;
  end

  always_comb begin
    state_next     = state;
    va_next        = va;
    vb_next        = vb;
    i_next         = i_idx;
    j_next         = j_idx;
    row_i_next     = row_i;
    res_count_next = res_count;
    res_valid_next = res_valid && !result.ready;
    mem_ctl        = '0;
    rd_addr        = va;
    wr_addr        = va;
    wr_data        = rd_data;
    pop_ctl        = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item.action)
            ACT_ADD_EDGE: begin
              if (edge_ok) begin
                va_next    = item.vertex_a[IW-1:0];
                vb_next    = item.vertex_b[IW-1:0];
                state_next = ST_ADD_RD_A;
              end
            end
            ACT_COUNT: begin
              pop_ctl.clr = 1'b1;
              i_next      = '0;
              state_next  = ST_CNT_RD_I;
            end
            ACT_CLEAR: begin
              mem_ctl.clr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ADD_RD_A: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = va;
        state_next    = ST_ADD_WR_A;
      end
      ST_ADD_WR_A: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = va;
        wr_data       = rd_data | (N'(1) << vb);
        mem_ctl.rd_en = 1'b1;
        rd_addr       = vb;
        state_next    = ST_ADD_WR_B;
      end
      ST_ADD_WR_B: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = vb;
        wr_data       = rd_data | (N'(1) << va);
        state_next    = ST_IDLE;
      end
      ST_CNT_RD_I: begin
        if (i_idx == I_LAST) begin
          state_next = ST_CNT_DONE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = i_idx;
          state_next    = ST_CNT_LD_I;
        end
      end
      ST_CNT_LD_I: begin
        row_i_next = rd_data;
        j_next     = i_idx + IW'(1);
        state_next = ST_CNT_SCAN;
      end
      ST_CNT_SCAN: begin
        if (row_i[j_idx]) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = j_idx;
          state_next    = ST_CNT_LD_J;
        end else if (j_idx == J_LAST) begin
          i_next     = i_idx + IW'(1);
          state_next = ST_CNT_RD_I;
        end else begin
          j_next = j_idx + IW'(1);
        end
      end
      ST_CNT_LD_J: begin
        // row j stays in the read register until the popcount unit frees up
        if (!pop_busy) begin
          pop_ctl.load = 1'b1;
          if (j_idx == J_LAST) begin
            i_next     = i_idx + IW'(1);
            state_next = ST_CNT_RD_I;
          end else begin
            j_next     = j_idx + IW'(1);
            state_next = ST_CNT_SCAN;
          end
        end
      end
      ST_CNT_DONE: begin
        if (!pop_busy && (!res_valid || result.ready)) begin
          res_valid_next = 1'b1;
          res_count_next = tally;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    pop_ctl.load |-> !pop_busy)
    else $error("popcount unit loaded while still busy");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.wr_en && mem_ctl.rd_en) |-> (wr_addr != rd_addr))
    else $error("row memory read and write at the same row");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_CNT_DONE))
    else $error("result raised outside count completion");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CNT_SCAN || state == ST_CNT_LD_J) |-> (j_idx > i_idx))
    else $error("pair scan with j not above i");

endmodule

/* tb/sv/tb_graph_triangle_counter_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_graph_triangle_counter_top
// Drives edge, count and clear requests with random sender bursts and
// receiver stalls, and predicts every triangle count from its own adjacency
// matrix. Each result is compared in order with the predicted count.
// ----------------------------------------------------------------------------

class triangle_tracker;
  logic [gtc_pkg::VERTEX_SPAN-1:0] adj_rows [gtc_pkg::VERTEX_SPAN];
  logic [gtc_pkg::COUNT_W-1:0]     expected_counts [$];
  int unsigned                     errors;

  function new();
    errors = 0;
    clear_graph();
  endfunction

  function void clear_graph();
    foreach (adj_rows[v]) adj_rows[v] = '0;
  endfunction

  function void note_request(input logic [gtc_pkg::ACTION_W-1:0] act,
                             input logic [gtc_pkg::VERTEX_W-1:0] va,
                             input logic [gtc_pkg::VERTEX_W-1:0] vb);
    int unsigned                     total;
    logic [gtc_pkg::VERTEX_SPAN-1:0] common;
    logic [gtc_pkg::VERTEX_SPAN-1:0] above_j;
    case (act)
      gtc_pkg::ACT_ADD_EDGE: begin
        // self-loops never stored, duplicates just set the same bits
        if (va != vb) begin
          adj_rows[va][vb] = 1'b1;
          adj_rows[vb][va] = 1'b1;
        end
      end
      gtc_pkg::ACT_COUNT: begin
        total = 0;
        for (int i = 0; i < gtc_pkg::VERTEX_SPAN; i++) begin
          for (int j = i + 1; j < gtc_pkg::VERTEX_SPAN; j++) begin
            if (adj_rows[i][j]) begin
              // common neighbours above j, so each triangle is seen once
              above_j = ~((64'd2 << j) - 64'd1);
              common  = adj_rows[i] & adj_rows[j] & above_j;
              total   = total + $countones(common);
            end
          end
        end
        if (total > gtc_pkg::COUNT_MAX) total = 32'(gtc_pkg::COUNT_MAX);
        expected_counts = {expected_counts, total[gtc_pkg::COUNT_W-1:0]};
      end
      gtc_pkg::ACT_CLEAR: clear_graph();
      default: ;
    endcase
  endfunction

  function void check_count(input logic [gtc_pkg::COUNT_W-1:0] got);
    logic [gtc_pkg::COUNT_W-1:0] want;
    if (expected_counts.size() == 0) begin
      $error("triangle_count: no result expected, actual %0d", got);
      errors++;
    end else begin
      want = expected_counts.pop_front();
      if (got !== want) begin
        $error("triangle_count mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    end
  endfunction
endclass

module tb_graph_triangle_counter_top;
  import gtc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;
  localparam int                  RANDOM_ITEMS = 1500;
  localparam int                  QUIET_LIMIT  = 100000;
  localparam int                  DRAIN_CYCLES = 50;

  logic clk;
  logic rst;

  gtc_item_if   item_ch ();
  gtc_result_if result_ch ();

  graph_triangle_counter_top #(
    .NUM_VERTICES(VERTEX_SPAN)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  triangle_tracker tracker = new();
  int unsigned     burst_left;
  int unsigned     quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: stall pattern changes at random intervals
  initial begin
    int unsigned mode;
    int unsigned span;
    result_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 300);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= ($urandom_range(0, 1) == 0);
          2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      tracker.check_count(result_ch.triangle_count);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(input logic [ACTION_W-1:0] act, input logic [VERTEX_W-1:0] va,
                      input logic [VERTEX_W-1:0] vb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk);
        item_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    item_ch.valid    <= 1'b1;
    item_ch.action   <= act;
    item_ch.vertex_a <= va;
    item_ch.vertex_b <= vb;
    do @(posedge clk); while (!item_ch.ready);
    tracker.note_request(act, va, vb);
  endtask

  // hold the sender off until every count has come back
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_counts.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned           sent;
    int unsigned           seq;
    int unsigned           pool_n;
    int unsigned           clique_n;
    int unsigned           n_edges;
    int unsigned           x;
    int unsigned           y;
    logic [VERTEX_W-1:0]   pool [$];
    logic [VERTEX_W-1:0]   v;
    logic [VERTEX_W-1:0]   last_a;
    logic [VERTEX_W-1:0]   last_b;
    logic                  used [VERTEX_SPAN];

    rst              = 1'b1;
    item_ch.valid    = 1'b0;
    item_ch.action   = ACT_ADD_EDGE;
    item_ch.vertex_a = '0;
    item_ch.vertex_b = '0;
    burst_left       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty graph, duplicates, self-loops, unused action, clear
    send(ACT_COUNT, 6'd0, 6'd0);
    send(ACT_ADD_EDGE, 6'd0, 6'd63);
    send(ACT_ADD_EDGE, 6'd63, 6'd0);
    send(ACT_ADD_EDGE, 6'd0, 6'd0);
    send(ACT_ADD_EDGE, 6'd63, 6'd63);
    send(ACT_ADD_EDGE, 6'd0, 6'd1);
    send(ACT_COUNT, 6'd63, 6'd63);
    send(ACT_ADD_EDGE, 6'd1, 6'd63);
    send(ACT_COUNT, 6'd0, 6'd0);
    send(ACT_UNUSED, 6'd63, 6'd63);
    send(ACT_UNUSED, 6'd0, 6'd0);
    send(ACT_ADD_EDGE, 6'd62, 6'd63);
    send(ACT_ADD_EDGE, 6'd0, 6'd62);
    send(ACT_ADD_EDGE, 6'd1, 6'd62);
    send(ACT_COUNT, 6'd21, 6'd42);
    send(ACT_ADD_EDGE, 6'd42, 6'd21);
    send(ACT_ADD_EDGE, 6'd21, 6'd0);
    send(ACT_ADD_EDGE, 6'd42, 6'd0);
    send(ACT_COUNT, 6'd0, 6'd0);
    send(ACT_CLEAR, 6'd63, 6'd63);
    send(ACT_COUNT, 6'd0, 6'd0);
    send(ACT_ADD_EDGE, 6'd21, 6'd42);
    send(ACT_COUNT, 6'd0, 6'd0);
    send(ACT_CLEAR, 6'd0, 6'd0);
    wait_drained();

    // random: build a graph over a vertex pool, then count it
    sent = 0;
    seq  = 0;
    while (sent < RANDOM_ITEMS) begin
      seq++;
      if ($urandom_range(0, 2) == 0) begin
        send(ACT_CLEAR, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)));
        sent++;
      end

      if (seq == 1) pool_n = 24;
      else if ($urandom_range(0, 3) == 0) pool_n = $urandom_range(8, 64);
      else pool_n = $urandom_range(3, 12);
      pool.delete();
      foreach (used[k]) used[k] = 1'b0;
      repeat (pool_n) begin
        do v = VERTEX_W'($urandom_range(0, 63)); while (used[v]);
        used[v] = 1'b1;
        pool = {pool, v};
      end

      if (seq == 1 || $urandom_range(0, 9) == 0) begin
        // dense clique, lots of triangles
        clique_n = (seq == 1) ? pool_n : $urandom_range(3, (pool_n < 12) ? pool_n : 12);
        for (int p = 0; p < clique_n; p++) begin
          for (int q = p + 1; q < clique_n; q++) begin
            if ($urandom_range(0, 1) == 0) send(ACT_ADD_EDGE, pool[p], pool[q]);
            else send(ACT_ADD_EDGE, pool[q], pool[p]);
            sent++;
          end
        end
      end else begin
        n_edges = $urandom_range(1, 30);
        last_a  = pool[0];
        last_b  = pool[1];
        repeat (n_edges) begin
          if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
              0: send(ACT_ADD_EDGE, pool[0], pool[0]);
              1: send(ACT_UNUSED, VERTEX_W'($urandom_range(0, 63)),
                      VERTEX_W'($urandom_range(0, 63)));
              default: begin
                send(ACT_ADD_EDGE, last_b, last_a);
                sent++;
              end
            endcase
          end else begin
            x      = $urandom_range(0, pool_n - 1);
            y      = (x + $urandom_range(1, pool_n - 1)) % pool_n;
            last_a = pool[x];
            last_b = pool[y];
            send(ACT_ADD_EDGE, last_a, last_b);
            sent++;
          end
        end
      end

      send(ACT_COUNT, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)));
      sent++;
      if ($urandom_range(0, 7) == 0) begin
        send(ACT_COUNT, VERTEX_W'($urandom_range(0, 63)), VERTEX_W'($urandom_range(0, 63)));
        sent++;
      end
      if (seq % 6 == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_counts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
